>>> sv/pfr_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// pfr_pkg
// Shared types, constants and coefficient table of the polyphase resampler.
// ---------------------------------------------------------------------------
package pfr_pkg;

  localparam int WINDOW_FRAMES_DEF = 16;
  localparam int MAX_CHANNELS_DEF  = 8;
  localparam int TAPS_PER_PHASE    = 16;
  localparam int PHASE_COUNT       = 8;
  localparam int IO_CHANNELS       = 8;
  localparam int MAX_RESULTS       = 4;

  localparam int SAMPLE_W = 24;
  localparam int COEF_W   = 16;
  localparam int PROD_W   = SAMPLE_W + COEF_W;
  localparam int ACC_W    = PROD_W + 4;
  localparam int POS_W    = 26;
  localparam int FRAC_W   = 20;
  localparam int STEP_W   = 23;
  localparam int CC_W     = 4;
  localparam int TAP_W    = 4;
  localparam int PHASE_W  = 3;
  localparam int RES_CNT_W = 3;

  localparam logic [POS_W-1:0]  POS_ONE  = POS_W'(1) << FRAC_W;
  localparam logic [POS_W-1:0]  POS_INIT = POS_W'(TAPS_PER_PHASE / 2) << FRAC_W;
  localparam logic [STEP_W-1:0] STEP_ONE = STEP_W'(1) << FRAC_W;
  localparam logic [CC_W-1:0]   CC_RESET = CC_W'(2);
  localparam logic [TAP_W-1:0]  TAP_LAST = TAP_W'(TAPS_PER_PHASE - 1);
  localparam logic [TAP_W-1:0]  TAP_CENTRE = TAP_W'(TAPS_PER_PHASE / 2);

  localparam logic CFG_CHANNEL_COUNT = 1'b0;
  localparam logic CFG_STEP_SIZE     = 1'b1;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] in_sample_0;
    logic signed [SAMPLE_W-1:0] in_sample_1;
    logic signed [SAMPLE_W-1:0] in_sample_2;
    logic signed [SAMPLE_W-1:0] in_sample_3;
    logic signed [SAMPLE_W-1:0] in_sample_4;
    logic signed [SAMPLE_W-1:0] in_sample_5;
    logic signed [SAMPLE_W-1:0] in_sample_6;
    logic signed [SAMPLE_W-1:0] in_sample_7;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] out_sample_0;
    logic signed [SAMPLE_W-1:0] out_sample_1;
    logic signed [SAMPLE_W-1:0] out_sample_2;
    logic signed [SAMPLE_W-1:0] out_sample_3;
    logic signed [SAMPLE_W-1:0] out_sample_4;
    logic signed [SAMPLE_W-1:0] out_sample_5;
    logic signed [SAMPLE_W-1:0] out_sample_6;
    logic signed [SAMPLE_W-1:0] out_sample_7;
    logic                       last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic               bypass;
    logic               last;
  } job_t;

  localparam logic signed [COEF_W-1:0] COEF_ROM [PHASE_COUNT][TAPS_PER_PHASE] = '{
    '{16'sd89, -16'sd146, -16'sd201, 16'sd893, 16'sd29, -16'sd3135, 16'sd2706, 16'sd16149,
      16'sd16149, 16'sd2706, -16'sd3135, 16'sd29, 16'sd893, -16'sd201, -16'sd146, 16'sd89},
    '{16'sd100, -16'sd113, -16'sd277, 16'sd799, 16'sd405, -16'sd3056, 16'sd1257, 16'sd14891,
      16'sd17189, 16'sd4274, -16'sd3060, -16'sd375, 16'sd947, -16'sd111, -16'sd174, 16'sd74},
    '{16'sd106, -16'sd75, -16'sd337, 16'sd671, 16'sd737, -16'sd2841, -16'sd46, 16'sd13447,
      16'sd17983, 16'sd5928, -16'sd2817, -16'sd793, 16'sd957, -16'sd12, -16'sd194, 16'sd54},
    '{16'sd106, -16'sd35, -16'sd378, 16'sd517, 16'sd1014, -16'sd2511, -16'sd1179, 16'sd11853,
      16'sd18511, 16'sd7633, -16'sd2397, -16'sd1206, 16'sd919, 16'sd94, -16'sd205, 16'sd30},
    '{16'sd46, 16'sd3, -16'sd180, 16'sd155, 16'sd552, -16'sd938, -16'sd954, 16'sd4559,
      16'sd26474, 16'sd4201, -16'sd806, -16'sd716, 16'sd373, 16'sd91, -16'sd93, 16'sd2},
    '{16'sd92, 16'sd46, -16'sd401, 16'sd163, 16'sd1373, -16'sd1596, -16'sd2871, 16'sd8375,
      16'sd18713, 16'sd11041, -16'sd1006, -16'sd1939, 16'sd694, 16'sd305, -16'sd197, -16'sd23},
    '{16'sd78, 16'sd82, -16'sd384, -16'sd20, 16'sd1446, -16'sd1061, -16'sd3411, 16'sd6575,
      16'sd18378, 16'sd12662, -16'sd39, -16'sd2218, 16'sd509, 16'sd400, -16'sd178, -16'sd51},
    '{16'sd61, 16'sd114, -16'sd348, -16'sd197, 16'sd1446, -16'sd508, -16'sd3745, 16'sd4791,
      16'sd17756, 16'sd14173, 16'sd1096, -16'sd2411, 16'sd283, 16'sd482, -16'sd148, -16'sd78}
  };

  function automatic logic signed [COEF_W-1:0] coef(input logic [PHASE_W-1:0] phase,
                                                     input logic [TAP_W-1:0] tap);
    return COEF_ROM[phase][tap];
  endfunction

endpackage
`default_nettype wire

>>> sv/polyphase_fractional_resampler.sv
`default_nettype none
// ---------------------------------------------------------------------------
// polyphase_fractional_resampler
// Eight-phase, sixteen-tap polyphase resampler for up to eight channels.
// ---------------------------------------------------------------------------
// The first input frame after reset is written into every row of the window
// (state S_FILL). Each output frame is then computed by the back end: the
// window memory delivers one tap row per cycle, so the 16 taps pass through the
// per-channel multiply-accumulate lanes serially. With up to four outputs per
// frame, a new frame is taken once all outputs of the last one are computed.
module polyphase_fractional_resampler #(
  parameter int WINDOW_FRAMES = pfr_pkg::WINDOW_FRAMES_DEF,
  parameter int MAX_CHANNELS  = pfr_pkg::MAX_CHANNELS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       push,
  output logic                            full,
  input  wire pfr_pkg::in_item_t          in_frame,
  output logic                            empty,
  input  wire logic                       pop,
  output pfr_pkg::out_item_t              out_frame,
  input  wire logic                       cfg_wen,
  input  wire logic                       cfg_idx,
  input  wire logic [pfr_pkg::STEP_W-1:0] cfg_data
);
  import pfr_pkg::*;

  localparam int AW    = $clog2(WINDOW_FRAMES);
  localparam int ROW_W = MAX_CHANNELS * SAMPLE_W;
  localparam int JOB_W = $bits(job_t);
  localparam int RES_W = $bits(out_item_t);

  logic [CC_W-1:0]   channel_count;
  logic [STEP_W-1:0] step_size;

  logic [SAMPLE_W-1:0] in_samp [IO_CHANNELS];
  logic [ROW_W-1:0]    row_in;

  logic          back_idle;
  logic          back_busy;
  logic          job_full;
  logic          job_empty;
  logic          job_push;
  logic          job_pop;
  job_t          job_w;
  logic [JOB_W-1:0] job_r;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [ROW_W-1:0] wr_data;
  logic [AW-1:0] newest;
  logic          res_push;
  logic          res_full;
  out_item_t     res_w;
  logic [RES_W-1:0] res_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count <= CC_RESET;
      step_size     <= STEP_ONE;
    end else if (cfg_wen) begin
      unique case (cfg_idx)
        CFG_CHANNEL_COUNT: channel_count <= cfg_data[CC_W-1:0];
        CFG_STEP_SIZE:     step_size     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign in_samp[0] = in_frame.in_sample_0;
  assign in_samp[1] = in_frame.in_sample_1;
  assign in_samp[2] = in_frame.in_sample_2;
  assign in_samp[3] = in_frame.in_sample_3;
  assign in_samp[4] = in_frame.in_sample_4;
  assign in_samp[5] = in_frame.in_sample_5;
  assign in_samp[6] = in_frame.in_sample_6;
  assign in_samp[7] = in_frame.in_sample_7;

  genvar c;
  generate
    for (c = 0; c < MAX_CHANNELS; c++) begin : g_row
      assign row_in[c*SAMPLE_W +: SAMPLE_W] = in_samp[c];
    end
  endgenerate

  assign back_idle = !back_busy && job_empty;

  pfr_front #(
    .WINDOW_FRAMES(WINDOW_FRAMES),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .row_in   (row_in),
    .step_size(step_size),
    .back_idle(back_idle),
    .job_full (job_full),
    .job_push (job_push),
    .job      (job_w),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .newest   (newest)
  );

  pfr_fifo #(
    .WIDTH(JOB_W),
    .DEPTH(MAX_RESULTS)
  ) u_job_q (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (job_push),
    .wr_data(job_w),
    .rd_en  (job_pop),
    .rd_data(job_r),
    .empty  (job_empty),
    .full   (job_full)
  );

  pfr_back #(
    .WINDOW_FRAMES(WINDOW_FRAMES),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .newest       (newest),
    .channel_count(channel_count),
    .job_empty    (job_empty),
    .job_in       (job_t'(job_r)),
    .job_pop      (job_pop),
    .res_full     (res_full),
    .res_push     (res_push),
    .res          (res_w),
    .busy         (back_busy)
  );

  pfr_fifo #(
    .WIDTH(RES_W),
    .DEPTH(MAX_RESULTS)
  ) u_res_q (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (res_push),
    .wr_data(res_w),
    .rd_en  (pop),
    .rd_data(res_r),
    .empty  (empty),
    .full   (res_full)
  );

  assign out_frame = out_item_t'(res_r);

`ifndef NO_ASSERTIONS
  a_no_write_while_busy: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> !back_busy && job_empty)
    else $error("window written while taps are being read");

  a_res_no_overflow: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result queue overflow");

  a_job_no_overflow: assert property (@(posedge clk) disable iff (rst)
    job_push |-> !job_full)
    else $error("job queue overflow");

  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    (push && !full) |=> !(job_pop && $past(job_empty)))
    else $error("job started from an empty queue");
`endif
endmodule
`default_nettype wire

>>> sv/pfr_fifo.sv
`default_nettype none
// ---------------------------------------------------------------------------
// pfr_fifo
// Small register queue, first in first out.
// ---------------------------------------------------------------------------
module pfr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  output logic      [WIDTH-1:0] rd_data,
  output logic                  empty,
  output logic                  full
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] store [DEPTH];
  logic [AW-1:0]    wptr;
  logic [AW-1:0]    rptr;
  logic [AW:0]      count;

  logic do_wr;
  logic do_rd;

  assign empty   = (count == '0);
  assign full    = (count == (AW+1)'(DEPTH));
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = store[rptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      store[wptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + AW'(1);
      end
      if (do_rd) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + AW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + (AW+1)'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - (AW+1)'(1);
      end
    end
  end
endmodule
`default_nettype wire

>>> sv/pfr_front.sv
`default_nettype none
// ---------------------------------------------------------------------------
// pfr_front
// Takes input frames, writes the window and issues one job per output frame.
// ---------------------------------------------------------------------------
module pfr_front #(
  parameter int WINDOW_FRAMES = pfr_pkg::WINDOW_FRAMES_DEF,
  parameter int MAX_CHANNELS  = pfr_pkg::MAX_CHANNELS_DEF,
  parameter int AW            = $clog2(WINDOW_FRAMES),
  parameter int ROW_W         = MAX_CHANNELS * pfr_pkg::SAMPLE_W
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         push,
  output logic                              full,
  input  wire logic [ROW_W-1:0]             row_in,
  input  wire logic [pfr_pkg::STEP_W-1:0]   step_size,
  input  wire logic                         back_idle,
  input  wire logic                         job_full,
  output logic                              job_push,
  output pfr_pkg::job_t                     job,
  output logic                              wr_en,
  output logic [AW-1:0]                     wr_addr,
  output logic [ROW_W-1:0]                  wr_data,
  output logic [AW-1:0]                     newest
);
  import pfr_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_FILL = 2'd1;
  localparam logic [1:0] S_GEN  = 2'd2;

  logic [1:0]           state;
  logic                 primed;
  logic [POS_W-1:0]     read_position;
  logic [ROW_W-1:0]     frame;
  logic [AW-1:0]        fill_cnt;
  logic [RES_CNT_W-1:0] res_cnt;

  logic             accept;
  logic [AW-1:0]    next_addr;
  logic [POS_W-1:0] pos_next;
  logic             want;

  assign full      = !((state == S_IDLE) && back_idle);
  assign accept    = push && !full;
  assign next_addr = (newest == AW'(WINDOW_FRAMES - 1)) ? '0 : newest + AW'(1);
  assign pos_next  = read_position + POS_W'(step_size);
  assign want      = (read_position < POS_ONE) && (res_cnt < RES_CNT_W'(MAX_RESULTS));

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = next_addr;
    wr_data = row_in;
    if (state == S_FILL) begin
      wr_en   = 1'b1;
      wr_addr = fill_cnt;
      wr_data = frame;
    end else if (accept && primed) begin
      wr_en = 1'b1;
    end
  end

  assign job_push   = (state == S_GEN) && want && !job_full;
  assign job.phase  = read_position[FRAC_W-1 -: PHASE_W];
  assign job.bypass = (step_size == STEP_ONE) && (read_position[FRAC_W-1:0] == '0);
  assign job.last   = (pos_next >= POS_ONE) || (res_cnt == RES_CNT_W'(MAX_RESULTS - 1));

  always_ff @(posedge clk) begin
    if (accept) begin
      frame <= row_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      primed        <= 1'b0;
      read_position <= '0;
      fill_cnt      <= '0;
      res_cnt       <= '0;
      newest        <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (!primed) begin
              fill_cnt <= '0;
              state    <= S_FILL;
            end else begin
              newest        <= next_addr;
              read_position <= (read_position >= POS_ONE) ? read_position - POS_ONE : '0;
              res_cnt       <= '0;
              state         <= S_GEN;
            end
          end
        end
        S_FILL: begin
          fill_cnt <= fill_cnt + AW'(1);
          if (fill_cnt == AW'(WINDOW_FRAMES - 1)) begin
            newest        <= fill_cnt;
            read_position <= POS_INIT;
            primed        <= 1'b1;
            state         <= S_IDLE;
          end
        end
        S_GEN: begin
          if (!want) begin
            state <= S_IDLE;
          end else if (!job_full) begin
            read_position <= pos_next;
            res_cnt       <= res_cnt + RES_CNT_W'(1);
            if (job.last) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end
endmodule
`default_nettype wire

>>> sv/pfr_back.sv
`default_nettype none
// ---------------------------------------------------------------------------
// pfr_back
// Window memory and per-channel multiply-accumulate lanes, one tap a cycle.
// ---------------------------------------------------------------------------
module pfr_back #(
  parameter int WINDOW_FRAMES = pfr_pkg::WINDOW_FRAMES_DEF,
  parameter int MAX_CHANNELS  = pfr_pkg::MAX_CHANNELS_DEF,
  parameter int AW            = $clog2(WINDOW_FRAMES),
  parameter int ROW_W         = MAX_CHANNELS * pfr_pkg::SAMPLE_W
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       wr_en,
  input  wire logic [AW-1:0]              wr_addr,
  input  wire logic [ROW_W-1:0]           wr_data,
  input  wire logic [AW-1:0]              newest,
  input  wire logic [pfr_pkg::CC_W-1:0]   channel_count,
  input  wire logic                       job_empty,
  input  wire pfr_pkg::job_t              job_in,
  output logic                            job_pop,
  input  wire logic                       res_full,
  output logic                            res_push,
  output pfr_pkg::out_item_t              res,
  output logic                            busy
);
  import pfr_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_RUN   = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;

  logic [ROW_W-1:0] mem [WINDOW_FRAMES];

  logic [1:0]               state;
  job_t                     job;
  logic [TAP_W-1:0]         tap;
  logic [TAP_W-1:0]         tap_d1;
  logic                     v1;
  logic                     v2;
  logic [ROW_W-1:0]         rdata;
  logic signed [COEF_W-1:0] coef_d1;
  logic [ROW_W-1:0]         centre;
  logic signed [PROD_W-1:0] prod [MAX_CHANNELS];
  logic signed [ACC_W-1:0]  acc  [MAX_CHANNELS];

  logic [AW:0]   addr_sum;
  logic [AW-1:0] rd_addr;
  logic          start;
  logic signed [SAMPLE_W-1:0] lane_out [IO_CHANNELS];

  assign addr_sum = {1'b0, newest} + (AW+1)'(WINDOW_FRAMES) - (AW+1)'(tap);
  assign rd_addr  = (addr_sum >= (AW+1)'(WINDOW_FRAMES)) ?
                    AW'(addr_sum - (AW+1)'(WINDOW_FRAMES)) : AW'(addr_sum);
  assign start    = (state == S_IDLE) && !job_empty && !res_full;
  assign job_pop  = start;
  assign busy     = (state != S_IDLE);
  assign res_push = (state == S_DRAIN) && !v1 && !v2;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    coef_d1 <= coef(job.phase, tap);
    tap_d1  <= tap;
    if (start) begin
      job <= job_in;
    end
    if (v1 && (tap_d1 == TAP_CENTRE)) begin
      centre <= rdata;
    end
  end

  genvar c;
  generate
    for (c = 0; c < MAX_CHANNELS; c++) begin : g_lane
      logic signed [ACC_W:0]  rnd;
      logic signed [ACC_W-15:0] q;
      logic lane_on;

      always_ff @(posedge clk) begin
        prod[c] <= $signed(rdata[c*SAMPLE_W +: SAMPLE_W]) * coef_d1;
        if (start) begin
          acc[c] <= '0;
        end else if (v2) begin
          acc[c] <= acc[c] + ACC_W'(prod[c]);
        end
      end

      assign rnd     = (ACC_W+1)'(acc[c]) + (ACC_W+1)'(16384);
      assign q       = rnd[ACC_W:15];
      assign lane_on = (CC_W'(c) < channel_count);

      always_comb begin
        if (!lane_on) begin
          lane_out[c] = '0;
        end else if (job.bypass) begin
          lane_out[c] = $signed(centre[c*SAMPLE_W +: SAMPLE_W]);
        end else if (q > (ACC_W-14)'(8388607)) begin
          lane_out[c] = 24'sh7FFFFF;
        end else if (q < -(ACC_W-14)'(8388608)) begin
          lane_out[c] = -24'sh800000;
        end else begin
          lane_out[c] = q[SAMPLE_W-1:0];
        end
      end
    end
    for (c = MAX_CHANNELS; c < IO_CHANNELS; c++) begin : g_unused
      assign lane_out[c] = '0;
    end
  endgenerate

  always_comb begin
    res.out_sample_0 = lane_out[0];
    res.out_sample_1 = lane_out[1];
    res.out_sample_2 = lane_out[2];
    res.out_sample_3 = lane_out[3];
    res.out_sample_4 = lane_out[4];
    res.out_sample_5 = lane_out[5];
    res.out_sample_6 = lane_out[6];
    res.out_sample_7 = lane_out[7];
    res.last_of_run  = job.last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      tap   <= '0;
      v1    <= 1'b0;
      v2    <= 1'b0;
    end else begin
      v1 <= (state == S_RUN);
      v2 <= v1;
      unique case (state)
        S_IDLE: begin
          tap <= '0;
          if (start) begin
            state <= S_RUN;
          end
        end
        S_RUN: begin
          tap <= tap + TAP_W'(1);
          if (tap == TAP_LAST) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (res_push) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end
endmodule
`default_nettype wire
